FILE: rtl/lrukv_pkg.sv
// Shared types and constants for the LRU key/value cache.
`default_nettype none

package lrukv_pkg;

    localparam int DEF_MAX_ENTRIES = 8;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic do_match;
        logic do_update;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key/value cache.
// Each accepted request beat is registered, then passes a match cycle and a rank and
// value-memory update cycle, after which its result beat is valid; the next request is
// taken during the update cycle once the output register is free.
// The result sits in an output register, so a new request is taken while it waits.
// Reset is synchronous and active low: it clears all valid bits, ranks and occupancy,
// sets capacity to 8, and needs no clearing pass.
`default_nettype none

module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = lrukv_pkg::DEF_MAX_ENTRIES
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Request stream.
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    input  wire [63:0]                      i_s_tdata,   // lookup_key [31:0], write_value [63:32]
    input  wire                             i_s_tuser,   // command [0]: 0 get, 1 put
    // Result stream.
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    output logic [31:0]                     o_m_tdata,   // read_value [31:0]
    output logic                            o_m_tuser,   // found [0]
    // Capacity register.
    input  wire                             i_cfg_we,
    input  wire [lrukv_pkg::CAP_W-1:0]      i_cfg_wdata
);
    import lrukv_pkg::*;

    t_ctrl_cmd  w_ctrl;
    t_dp_status w_status;

    // The controller steps each request through accept, match and update.
    lrukv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    // The datapath holds the entries, compares every key in parallel and
    // keeps the recency ranks as a permutation of the valid entries.
    lrukv_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_status      (w_status),
        .i_command     (i_s_tuser),
        .i_lookup_key  (i_s_tdata[KEY_W-1:0]),
        .i_write_value (i_s_tdata[KEY_W+VAL_W-1:KEY_W]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_found       (o_m_tuser),
        .o_read_value  (o_m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/lrukv_ctrl.sv
// Request sequencer for the LRU key/value cache: accept, match, update.
`default_nettype none

module lrukv_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    input  lrukv_pkg::t_dp_status   i_status,
    output lrukv_pkg::t_ctrl_cmd    o_ctrl
);
    import lrukv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // A new request may enter while the previous one retires.
    assign o_s_tready = (r_state == S_IDLE) || ((r_state == S_UPDATE) && i_status.out_free);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        o_ctrl.load_in   = w_accept;
        o_ctrl.do_match  = (r_state == S_MATCH);
        o_ctrl.do_update = (r_state == S_UPDATE) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_MATCH;
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.out_free) n_state = w_accept ? S_MATCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lrukv_dp.sv
// Datapath of the LRU key/value cache: key match cells, recency ranks, value memory.
`default_nettype none

module lrukv_dp #(
    parameter int MAX_ENTRIES = lrukv_pkg::DEF_MAX_ENTRIES
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  lrukv_pkg::t_ctrl_cmd            i_ctrl,
    output lrukv_pkg::t_dp_status           o_status,
    input  wire                             i_command,
    input  wire [lrukv_pkg::KEY_W-1:0]      i_lookup_key,
    input  wire [lrukv_pkg::VAL_W-1:0]      i_write_value,
    input  wire                             i_cfg_we,
    input  wire [lrukv_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  wire                             i_m_tready,
    output logic                            o_m_tvalid,
    output logic                            o_found,
    output logic [lrukv_pkg::VAL_W-1:0]     o_read_value
);
    import lrukv_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

    // Request registers.
    logic             r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    logic [CAP_W-1:0] r_capacity;

    // Entry state.
    logic [KEY_W-1:0]       r_keys [MAX_ENTRIES];
    logic [VAL_W-1:0]       r_value_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]       r_rank [MAX_ENTRIES];
    logic [OCC_W-1:0]       r_occ;

    logic [MAX_ENTRIES-1:0] n_valid;
    logic [IDX_W-1:0]       n_rank [MAX_ENTRIES];
    logic [OCC_W-1:0]       n_occ;

    // Match stage results.
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_hit_rank;
    logic [VAL_W-1:0] r_rd_data;

    // Output register.
    logic             r_out_valid;
    logic             r_out_found;
    logic [VAL_W-1:0] r_out_value;

    logic [MAX_ENTRIES-1:0] w_match_vec;
    logic                   w_match_any;
    logic [IDX_W-1:0]       w_match_idx;
    logic [IDX_W-1:0]       w_match_rank;

    logic [OCC_W-1:0]       w_eff_cap;
    logic [OCC_W-1:0]       w_occ_m1;
    logic [IDX_W-1:0]       w_oldest;
    logic                   w_evict;
    logic [MAX_ENTRIES-1:0] w_victim_vec;
    logic [MAX_ENTRIES-1:0] w_keep;
    logic                   w_free_any;
    logic [IDX_W-1:0]       w_free_idx;
    logic                   w_insert;
    logic                   w_out_free;

    assign w_out_free        = !r_out_valid || i_m_tready;
    assign o_status.out_free = w_out_free;
    assign o_m_tvalid        = r_out_valid;
    assign o_found           = r_out_found;
    assign o_read_value      = r_out_value;

    // Each entry compares its own key; keys of valid entries are unique.
    always_comb begin
        w_match_any  = 1'b0;
        w_match_idx  = '0;
        w_match_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match_vec[i] = r_valid[i] && (r_keys[i] == r_key);
        end
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (w_match_vec[i]) begin
                w_match_any  = 1'b1;
                w_match_idx  = IDX_W'(i);
                w_match_rank = r_rank[i];
            end
        end
    end

    // Capacity of zero acts as one; values above the entry count saturate.
    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = OCC_W'(1);
        end else if (32'(r_capacity) > 32'(MAX_ENTRIES)) begin
            w_eff_cap = OCC_W'(MAX_ENTRIES);
        end else begin
            w_eff_cap = OCC_W'(r_capacity);
        end
    end

    // Valid ranks form a permutation, so the least recent entry is the one
    // whose rank equals occupancy minus one.
    assign w_occ_m1 = r_occ - OCC_W'(1);
    assign w_oldest = w_occ_m1[IDX_W-1:0];
    assign w_evict  = (r_occ >= w_eff_cap);
    assign w_insert = i_ctrl.do_update && (r_cmd == CMD_PUT) && !r_hit;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_victim_vec[i] = r_valid[i] && w_evict && (r_rank[i] == w_oldest);
        end
        w_keep     = r_valid & ~w_victim_vec;
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!w_keep[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (i_ctrl.do_update) begin
            if (r_hit) begin
                // Promote: entries more recent than the hit age by one.
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                        n_rank[i] = r_rank[i] + IDX_W'(1);
                    end
                end
                n_rank[r_hit_idx] = '0;
            end else if (r_cmd == CMD_PUT) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (w_keep[i]) begin
                        n_rank[i] = r_rank[i] + IDX_W'(1);
                    end else if (w_victim_vec[i]) begin
                        n_rank[i] = '0;
                    end
                end
                n_valid             = w_keep;
                n_valid[w_free_idx] = 1'b1;
                n_rank[w_free_idx]  = '0;
                n_occ = r_occ + OCC_W'(1) - (w_evict ? OCC_W'(1) : OCC_W'(0));
            end
        end
    end

    // Request and match-stage payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_cmd <= i_command;
            r_key <= i_lookup_key;
            r_val <= i_write_value;
        end
        if (i_ctrl.do_match) begin
            r_hit      <= w_match_any;
            r_hit_idx  <= w_match_idx;
            r_hit_rank <= w_match_rank;
        end
    end

    // Value memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.do_match) begin
            r_rd_data <= r_value_mem[w_match_idx];
        end
        if (i_ctrl.do_update && (r_cmd == CMD_PUT)) begin
            r_value_mem[r_hit ? r_hit_idx : w_free_idx] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_keys[w_free_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_occ      <= '0;
            r_capacity <= CAP_RESET;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.do_update) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.do_update) begin
            r_out_found <= r_hit;
            r_out_value <= ((r_cmd == CMD_GET) && r_hit) ? r_rd_data : '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(MAX_ENTRIES))
        else $error("occupancy exceeds entry count");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy does not match valid entries");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match_vec))
        else $error("key present in more than one entry");

    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |-> w_free_any)
        else $error("insert without a free entry");

    a_update_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.do_update |=> (r_out_valid && (r_out_found == $past(r_hit))))
        else $error("result not registered after update");
`endif

endmodule

`default_nettype wire
